// File: hw/rtl/steering_button_command_mapper_defines.svh
// Assertion macros for the steering button command mapper.
`ifndef STEERING_BUTTON_COMMAND_MAPPER_DEFINES_SVH
`define STEERING_BUTTON_COMMAND_MAPPER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SBCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SBCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SBCM_ASSERT(lbl, prop, msg)
`define SBCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/sbcm_pkg.sv
package sbcm_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_EVENT   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    EV_NEXT_REL = 4'd0,
    EV_PREV_REL = 4'd1,
    EV_VOLUP    = 4'd2,
    EV_VOLDN    = 4'd3,
    EV_NEXT     = 4'd4,
    EV_PREV     = 4'd5,
    EV_RT       = 4'd6,
    EV_DIAL     = 4'd7,
    EV_DIAL1S   = 4'd8,
    EV_DIALREL  = 4'd9,
    EV_ACC      = 4'd10,
    EV_START    = 4'd11,
    EV_ON       = 4'd12,
    EV_OTHER    = 4'd13
  } event_e;

  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_TUNER_REL = 4'd1,
    CMD_TUNEL_REL = 4'd2,
    CMD_VOLUP     = 4'd3,
    CMD_VOLDN     = 4'd4,
    CMD_TUNER     = 4'd5,
    CMD_TUNEL     = 4'd6,
    CMD_SOURCE    = 4'd7,
    CMD_ANSWER    = 4'd8,
    CMD_REJECT    = 4'd9,
    CMD_FOLDERUP  = 4'd10,
    CMD_FOLDERDN  = 4'd11,
    CMD_MUTE      = 4'd12
  } cmd_e;

  typedef enum logic [1:0] {
    DIAL_IDLE    = 2'd0,
    DIAL_PRESSED = 2'd1,
    DIAL_HELD    = 2'd2
  } dial_e;

  typedef enum logic [1:0] {
    IGN_NONE  = 2'd0,
    IGN_ACC   = 2'd1,
    IGN_START = 2'd2
  } ign_e;

  typedef enum logic [1:0] {
    CFG_ALT_MODE_TICKS       = 2'd0,
    CFG_AFTER_COMMAND_TICKS  = 2'd1,
    CFG_STARTUP_WINDOW_TICKS = 2'd2
  } cfg_idx_e;

  localparam int unsigned AltW     = 16;
  localparam int unsigned StartupW = 14;

  localparam logic [AltW-1:0]     AltModeTicksRst       = 16'd3000;
  localparam logic [AltW-1:0]     AfterCommandTicksRst  = 16'd10;
  localparam logic [StartupW-1:0] StartupWindowTicksRst = 14'd12000;

  localparam logic [StartupW-1:0] Win0Lo = 14'd10000;
  localparam logic [StartupW-1:0] Win0Hi = 14'd11000;
  localparam logic [StartupW-1:0] Win1Lo = 14'd6000;
  localparam logic [StartupW-1:0] Win1Hi = 14'd7000;
  localparam logic [StartupW-1:0] Win2Lo = 14'd1000;
  localparam logic [StartupW-1:0] Win2Hi = 14'd2000;

endpackage

// File: hw/rtl/steering_button_command_mapper.sv
// Each input transfer's result lands in the output register in the next cycle.
// Throughput: 1 item per cycle while results are taken; a new item enters as one leaves.
// The state update and command decode sit between the input port and the result register.
// Reset (rst_ni low, async): timers, modes and output valid clear, startup timer
// loads 12000 and the configuration registers take their default values.
`include "steering_button_command_mapper_defines.svh"

module steering_button_command_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  event_code_i,
  input  logic        watchdog_restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  command_o,
  output logic        alt_mode_active_o,
  output logic        source_blocked_o
);

  logic [sbcm_pkg::AltW-1:0]     alt_mode_ticks_q;
  logic [sbcm_pkg::AltW-1:0]     after_cmd_ticks_q;
  logic [sbcm_pkg::StartupW-1:0] startup_win_q;

  logic [sbcm_pkg::AltW-1:0]     alt_timer_q, alt_timer_d;
  logic                          alt_hold_q, alt_hold_d;
  logic [sbcm_pkg::StartupW-1:0] startup_timer_q, startup_timer_d;
  logic                          src_sup_q, src_sup_d;
  sbcm_pkg::dial_e               dial_q, dial_d;
  sbcm_pkg::ign_e                ign_q, ign_d;

  sbcm_pkg::cmd_e                cmd_d, command_q;
  logic                          out_valid_q;
  logic                          in_fire;
  logic                          alt_zero;
  logic [sbcm_pkg::StartupW-1:0] st_dec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign alt_zero   = (alt_timer_q == '0);
  assign st_dec     = startup_timer_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_mode_ticks_q  <= sbcm_pkg::AltModeTicksRst;
      after_cmd_ticks_q <= sbcm_pkg::AfterCommandTicksRst;
      startup_win_q     <= sbcm_pkg::StartupWindowTicksRst;
    end else if (cfg_we_i) begin
      unique case (sbcm_pkg::cfg_idx_e'(cfg_idx_i))
        sbcm_pkg::CFG_ALT_MODE_TICKS:       alt_mode_ticks_q  <= cfg_data_i;
        sbcm_pkg::CFG_AFTER_COMMAND_TICKS:  after_cmd_ticks_q <= cfg_data_i;
        sbcm_pkg::CFG_STARTUP_WINDOW_TICKS: startup_win_q     <= cfg_data_i[sbcm_pkg::StartupW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    alt_timer_d     = alt_timer_q;
    alt_hold_d      = alt_hold_q;
    startup_timer_d = startup_timer_q;
    src_sup_d       = src_sup_q;
    dial_d          = dial_q;
    ign_d           = ign_q;
    cmd_d           = sbcm_pkg::CMD_NONE;
    unique case (sbcm_pkg::op_e'(op_i))
      sbcm_pkg::OP_TICK: begin
        if (!alt_zero && !alt_hold_q) begin
          alt_timer_d = alt_timer_q - 1'b1;
        end
        if (startup_timer_q != '0) begin
          startup_timer_d = st_dec;
          src_sup_d = (st_dec > sbcm_pkg::Win0Lo && st_dec < sbcm_pkg::Win0Hi) ||
                      (st_dec > sbcm_pkg::Win1Lo && st_dec < sbcm_pkg::Win1Hi) ||
                      (st_dec > sbcm_pkg::Win2Lo && st_dec < sbcm_pkg::Win2Hi);
        end
      end
      sbcm_pkg::OP_EVENT: begin
        unique case (sbcm_pkg::event_e'(event_code_i))
          sbcm_pkg::EV_NEXT_REL: begin
            if (alt_zero) cmd_d = sbcm_pkg::CMD_TUNER_REL;
          end
          sbcm_pkg::EV_PREV_REL: begin
            if (alt_zero) cmd_d = sbcm_pkg::CMD_TUNEL_REL;
          end
          sbcm_pkg::EV_VOLUP: begin
            if (alt_zero) begin
              cmd_d = sbcm_pkg::CMD_VOLUP;
            end else begin
              cmd_d       = sbcm_pkg::CMD_ANSWER;
              alt_timer_d = after_cmd_ticks_q;
            end
          end
          sbcm_pkg::EV_VOLDN: begin
            if (alt_zero) begin
              cmd_d = sbcm_pkg::CMD_VOLDN;
            end else begin
              cmd_d       = sbcm_pkg::CMD_REJECT;
              alt_timer_d = after_cmd_ticks_q;
            end
          end
          sbcm_pkg::EV_NEXT: begin
            if (alt_zero) begin
              cmd_d = sbcm_pkg::CMD_TUNER;
            end else begin
              cmd_d       = sbcm_pkg::CMD_FOLDERUP;
              alt_timer_d = after_cmd_ticks_q;
            end
          end
          sbcm_pkg::EV_PREV: begin
            if (alt_zero) begin
              cmd_d = sbcm_pkg::CMD_TUNEL;
            end else begin
              cmd_d       = sbcm_pkg::CMD_FOLDERDN;
              alt_timer_d = after_cmd_ticks_q;
            end
          end
          sbcm_pkg::EV_RT: begin
            if (!src_sup_q) begin
              if (alt_zero) begin
                cmd_d = sbcm_pkg::CMD_SOURCE;
              end else begin
                cmd_d       = sbcm_pkg::CMD_MUTE;
                alt_timer_d = after_cmd_ticks_q;
              end
            end
          end
          sbcm_pkg::EV_DIAL:   dial_d = sbcm_pkg::DIAL_PRESSED;
          sbcm_pkg::EV_DIAL1S: dial_d = sbcm_pkg::DIAL_HELD;
          sbcm_pkg::EV_DIALREL: begin
            if (dial_q == sbcm_pkg::DIAL_PRESSED) begin
              alt_hold_d = 1'b0;
            end else if (dial_q == sbcm_pkg::DIAL_HELD) begin
              alt_hold_d = 1'b1;
            end
            dial_d      = sbcm_pkg::DIAL_IDLE;
            alt_timer_d = alt_zero ? alt_mode_ticks_q : '0;
          end
          sbcm_pkg::EV_ACC: begin
            ign_d           = sbcm_pkg::IGN_ACC;
            startup_timer_d = startup_win_q;
          end
          sbcm_pkg::EV_START: ign_d = sbcm_pkg::IGN_START;
          sbcm_pkg::EV_ON: begin
            if (ign_q == sbcm_pkg::IGN_START) begin
              startup_timer_d = startup_win_q;
            end
            ign_d = sbcm_pkg::IGN_NONE;
          end
          default: ;
        endcase
      end
      sbcm_pkg::OP_RESTART: begin
        alt_timer_d     = '0;
        alt_hold_d      = 1'b0;
        src_sup_d       = 1'b0;
        dial_d          = sbcm_pkg::DIAL_IDLE;
        ign_d           = sbcm_pkg::IGN_NONE;
        startup_timer_d = watchdog_restart_i ? '0 : startup_win_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_timer_q     <= '0;
      alt_hold_q      <= 1'b0;
      startup_timer_q <= sbcm_pkg::StartupWindowTicksRst;
      src_sup_q       <= 1'b0;
      dial_q          <= sbcm_pkg::DIAL_IDLE;
      ign_q           <= sbcm_pkg::IGN_NONE;
    end else if (in_fire) begin
      alt_timer_q     <= alt_timer_d;
      alt_hold_q      <= alt_hold_d;
      startup_timer_q <= startup_timer_d;
      src_sup_q       <= src_sup_d;
      dial_q          <= dial_d;
      ign_q           <= ign_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload, no reset
  logic alt_act_q, src_blk_q;
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      command_q <= cmd_d;
      alt_act_q <= (alt_timer_d != '0);
      src_blk_q <= src_sup_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign command_o         = command_q;
  assign alt_mode_active_o = alt_act_q;
  assign source_blocked_o  = src_blk_q;

  `SBCM_ASSERT(a_alt_flag_tracks_timer, in_fire |=> (alt_mode_active_o == (alt_timer_q != '0)), "alt_mode_active_o disagrees with alternate timer")
  `SBCM_ASSERT(a_src_flag_tracks_state, in_fire |=> (source_blocked_o == src_sup_q), "source_blocked_o disagrees with suppression state")
  `SBCM_ASSERT(a_cmd_only_on_event, (in_fire && op_i != sbcm_pkg::OP_EVENT) |=> (command_o == sbcm_pkg::CMD_NONE), "command issued for a tick or restart")
  `SBCM_ASSERT(a_hold_freezes_timer, (in_fire && op_i == sbcm_pkg::OP_TICK && alt_hold_q) |=> $stable(alt_timer_q), "alternate timer counted while held")
  `SBCM_ASSERT_ALWAYS(a_reset_clears_valid, $rose(rst_ni) |-> !out_valid_o, "output valid on reset release")

endmodule
